@@ rtl/accel_tilt_angles_assert.svh @@
// Assertion macros for the accelerometer tilt angle block.
// Used by accel_tilt_angles.sv; needs no other file.
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH

// Property that must hold on every clock while out of reset
`define ATA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Angle field stays within plus or minus ninety degrees
`define ATA_RANGE(label, vld, ang, msg) \
    `ATA_ASSERT(label, (vld) |-> (($signed(ang) >= -8'sd90) && ($signed(ang) <= 8'sd90)), msg)

`endif

@@ rtl/ata_pkg.sv @@
// Package for the accelerometer tilt angle block: types and the degree table.
// Self-contained; used by every module of the block.
`timescale 1ns / 1ps

package ata_pkg;

    localparam int NumSteps = 7;
    localparam logic [63:0] PiQ62 = 64'hC90FDAA22168C234;
    localparam logic [6:0] MaxDeg = 7'd90;

    // One angle under search
    typedef struct packed {
        logic [30:0] n2;
        logic [31:0] s;
        logic        neg;
        logic [6:0]  lo;
        logic [6:0]  hi;
    } t_lane;

    // Item travelling down the pipe: lane 0 is x tilt, lane 1 is y tilt
    typedef struct packed {
        logic            vld;
        t_lane [1:0]     lanes;
    } t_item;

    // cos^2 and sin^2 of one degree, both Q62
    typedef struct packed {
        logic [63:0] c2;
        logic [63:0] s2;
    } t_coef;

    typedef t_coef [90:0] t_tab;

    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Taylor term divided by (2k)(2k+1)
    function automatic logic [63:0] tdiv(input logic [63:0] t, input int k);
        logic [63:0] r;
        case (k)
            1: r = t / 64'd6;      2: r = t / 64'd20;     3: r = t / 64'd42;
            4: r = t / 64'd72;     5: r = t / 64'd110;    6: r = t / 64'd156;
            7: r = t / 64'd210;    8: r = t / 64'd272;    9: r = t / 64'd342;
            10: r = t / 64'd420;   11: r = t / 64'd506;   12: r = t / 64'd600;
            13: r = t / 64'd702;   14: r = t / 64'd812;   15: r = t / 64'd930;
            16: r = t / 64'd1056;  17: r = t / 64'd1190;  18: r = t / 64'd1332;
            19: r = t / 64'd1482;  20: r = t / 64'd1640;  21: r = t / 64'd1806;
            22: r = t / 64'd1980;  23: r = t / 64'd2162;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

    // sin of d degrees in Q62
    function automatic logic [63:0] sin_deg(input int d);
        logic [63:0] x, term, sum, dd;
        dd = 64'(d);
        x = (PiQ62 / 64'd180) * dd + ((PiQ62 % 64'd180) * dd) / 64'd180;
        term = x;
        sum = x;
        for (int k = 1; k < 24; k++) begin
            if (term != 64'd0) begin
                term = tdiv(mulq(mulq(term, x), x), k);
                if (k % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic t_tab build_tab();
        t_tab tab;
        logic [63:0] sn, cs;
        for (int d = 0; d <= 90; d++) begin
            sn = sin_deg(d);
            cs = sin_deg(90 - d);
            tab[d].c2 = mulq(cs, cs);
            tab[d].s2 = mulq(sn, sn);
        end
        return tab;
    endfunction

    localparam t_tab CoefTab = build_tab();

endpackage

@@ rtl/ata_square.sv @@
// Front end: squares of the three axes, then the two search lanes.
// Depends on ata_pkg.
`timescale 1ns / 1ps

module ata_square (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  logic             i_vld,
    input  logic [15:0]      i_ax,
    input  logic [15:0]      i_ay,
    input  logic [15:0]      i_az,
    output ata_pkg::t_item   o_item
);

    logic [15:0] n_mx, n_my, n_mz;
    logic [30:0] r_xx, r_yy, r_zz, n_xx, n_yy, n_zz;
    logic        r_v1, r_nx, r_ny;
    ata_pkg::t_item r_item, n_item;

    // magnitudes; 32768 fits unsigned
    assign n_mx = i_ax[15] ? 16'(-i_ax) : i_ax;
    assign n_my = i_ay[15] ? 16'(-i_ay) : i_ay;
    assign n_mz = i_az[15] ? 16'(-i_az) : i_az;
    assign n_xx = 31'({16'd0, n_mx} * {16'd0, n_mx});
    assign n_yy = 31'({16'd0, n_my} * {16'd0, n_my});
    assign n_zz = 31'({16'd0, n_mz} * {16'd0, n_mz});

    // second stage: sums and fresh search bounds
    always_comb begin
        n_item = r_item;
        n_item.vld = r_v1;
        n_item.lanes[0].n2  = r_xx;
        n_item.lanes[0].s   = {1'b0, r_yy} + {1'b0, r_zz};
        n_item.lanes[0].neg = r_nx;
        n_item.lanes[0].lo  = 7'd0;
        n_item.lanes[0].hi  = ata_pkg::MaxDeg;
        n_item.lanes[1].n2  = r_yy;
        n_item.lanes[1].s   = {1'b0, r_xx} + {1'b0, r_zz};
        n_item.lanes[1].neg = r_ny;
        n_item.lanes[1].lo  = 7'd0;
        n_item.lanes[1].hi  = ata_pkg::MaxDeg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_item.vld <= 1'b0;
        end else if (i_ce) begin
            r_v1 <= i_vld;
            r_item.vld <= n_item.vld;
        end
        if (i_ce) begin
            r_xx <= n_xx;
            r_yy <= n_yy;
            r_zz <= n_zz;
            r_nx <= i_ax[15];
            r_ny <= i_ay[15];
            r_item.lanes <= n_item.lanes;
        end
    end

    assign o_item = r_item;

endmodule

@@ rtl/ata_search_step.sv @@
// One bisection step over whole degrees: products, then compare and narrow.
// Depends on ata_pkg for the item type and the degree table.
`timescale 1ns / 1ps

module ata_search_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_ce,
    input  ata_pkg::t_item   i_item,
    output ata_pkg::t_item   o_item
);

    ata_pkg::t_item r_a, r_b, n_b;
    logic [6:0]  r_mid [2];
    logic [62:0] r_pl_lo [2];
    logic [62:0] r_pl_hi [2];
    logic [63:0] r_pr_lo [2];
    logic [63:0] r_pr_hi [2];
    logic [6:0]  n_mid [2];
    logic [7:0]  n_sum [2];
    logic [95:0] n_lhs [2];
    logic [95:0] n_rhs [2];

    // stage A: midpoint and the partial products of both sides
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_sum[l] = {1'b0, i_item.lanes[l].lo} + {1'b0, i_item.lanes[l].hi} + 8'd1;
            n_mid[l] = n_sum[l][7:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.vld <= 1'b0;
        end else if (i_ce) begin
            r_a.vld <= i_item.vld;
        end
        if (i_ce) begin
            r_a.lanes <= i_item.lanes;
            for (int l = 0; l < 2; l++) begin
                r_mid[l]   <= n_mid[l];
                r_pl_lo[l] <= {32'd0, i_item.lanes[l].n2}
                              * {31'd0, ata_pkg::CoefTab[n_mid[l]].c2[31:0]};
                r_pl_hi[l] <= {32'd0, i_item.lanes[l].n2}
                              * {31'd0, ata_pkg::CoefTab[n_mid[l]].c2[63:32]};
                r_pr_lo[l] <= {32'd0, i_item.lanes[l].s}
                              * {32'd0, ata_pkg::CoefTab[n_mid[l]].s2[31:0]};
                r_pr_hi[l] <= {32'd0, i_item.lanes[l].s}
                              * {32'd0, ata_pkg::CoefTab[n_mid[l]].s2[63:32]};
            end
        end
    end

    // stage B: keep the midpoint when n^2 cos^2 >= s sin^2 (exact products)
    always_comb begin
        n_b = r_a;
        for (int l = 0; l < 2; l++) begin
            n_lhs[l] = {1'b0, r_pl_hi[l], 32'd0} + {33'd0, r_pl_lo[l]};
            n_rhs[l] = {r_pr_hi[l], 32'd0} + {32'd0, r_pr_lo[l]};
            if (n_lhs[l] >= n_rhs[l]) n_b.lanes[l].lo = r_mid[l];
            else n_b.lanes[l].hi = r_mid[l] - 7'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.vld <= 1'b0;
        end else if (i_ce) begin
            r_b.vld <= n_b.vld;
        end
        if (i_ce) r_b.lanes <= n_b.lanes;
    end

    assign o_item = r_b;

endmodule

@@ rtl/accel_tilt_angles.sv @@
// Accelerometer tilt angles: one sample in, x and y tilt in whole degrees out.
// Top level; depends on ata_pkg, ata_square, ata_search_step and the assert header.
//
// Usage:
//  Slave channel carries one sample per request: tdata = {az, ay, ax}, ax lowest.
//  Master channel carries {tilt_y_deg, tilt_x_deg}, x in the low byte.
//  Each angle is the largest whole degree d with n^2 cos^2(d) >= s sin^2(d),
//  found by a seven-step bisection over a constant table of 91 degrees.
//  The pipe has two front-end stages, two per bisection step and one output
//  register. Throughput is one sample per cycle while the pipe is not held.
//  The whole pipe advances together; it holds when the output register is
//  full and the master side is not ready, and s_tready falls with it, so
//  nothing is dropped or repeated.
//  Reset clears every valid bit; no clearing pass is needed.
//  Samples are independent: there is no state between them.
`timescale 1ns / 1ps
`include "accel_tilt_angles_assert.svh"

module accel_tilt_angles (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // tilt_x_deg[7:0], tilt_y_deg[15:8]
);

    logic ce;
    ata_pkg::t_item stage [ata_pkg::NumSteps + 1];
    logic        r_vld;
    logic [7:0]  r_tx, r_ty, n_ang [2];

    // pipe advances unless a finished result is waiting and the master side is not ready
    assign ce = !r_vld || m_tready;
    assign s_tready = ce;

    ata_square u_square (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ce   (ce),
        .i_vld  (s_tvalid),
        .i_ax   (s_tdata[15:0]),
        .i_ay   (s_tdata[31:16]),
        .i_az   (s_tdata[47:32]),
        .o_item (stage[0])
    );

    for (genvar g = 0; g < ata_pkg::NumSteps; g++) begin : g_step
        ata_search_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ce   (ce),
            .i_item (stage[g]),
            .o_item (stage[g + 1])
        );
    end

    // zero numerator gives zero; otherwise apply the sign
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (stage[ata_pkg::NumSteps].lanes[l].n2 == 31'd0) n_ang[l] = 8'd0;
            else if (stage[ata_pkg::NumSteps].lanes[l].neg)
                n_ang[l] = 8'(-{1'b0, stage[ata_pkg::NumSteps].lanes[l].lo});
            else n_ang[l] = {1'b0, stage[ata_pkg::NumSteps].lanes[l].lo};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (ce) begin
            r_vld <= stage[ata_pkg::NumSteps].vld;
        end
        if (ce) begin
            r_tx <= n_ang[0];
            r_ty <= n_ang[1];
        end
    end

    assign m_tvalid = r_vld;
    assign m_tdata  = {r_ty, r_tx};

    `ATA_RANGE(a_range_x, m_tvalid, m_tdata[7:0], "x tilt out of range")
    `ATA_RANGE(a_range_y, m_tvalid, m_tdata[15:8], "y tilt out of range")
    `ATA_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "result lost")
    `ATA_ASSERT(a_ready, (!s_tready) |-> (m_tvalid && !m_tready), "input stalled without cause")

endmodule
